// File: design/ism_pkg.sv
`timescale 1ns / 1ps

package ism_pkg;

    // Field widths of one instruction item and one result item
    localparam int KindW  = 4;
    localparam int WordW  = 32;
    localparam int VidxW  = 6;

    typedef logic [KindW-1:0] kind_t;
    typedef logic [WordW-1:0] word_t;
    typedef logic [VidxW-1:0] vidx_t;

    // Opcodes
    localparam kind_t OP_CONST = 4'd0;
    localparam kind_t OP_LOAD  = 4'd1;
    localparam kind_t OP_STORE = 4'd2;
    localparam kind_t OP_ADD   = 4'd3;
    localparam kind_t OP_SUB   = 4'd4;
    localparam kind_t OP_MUL   = 4'd5;
    localparam kind_t OP_DIV   = 4'd6;
    localparam kind_t OP_EMIT  = 4'd7;
    localparam kind_t OP_HALT  = 4'd8;

endpackage

// File: design/ism_cmd_if.sv
`timescale 1ns / 1ps

interface ism_cmd_if;
    logic           valid;
    logic           ready;
    ism_pkg::kind_t kind;
    ism_pkg::word_t constant_value;
    ism_pkg::vidx_t var_index;

    modport source (output valid, output kind, output constant_value, output var_index,
                    input ready);
    modport sink   (input valid, input kind, input constant_value, input var_index,
                    output ready);
endinterface

// File: design/ism_res_if.sv
`timescale 1ns / 1ps

interface ism_res_if;
    logic           valid;
    logic           ready;
    ism_pkg::word_t printed_value;
    logic           halted;

    modport source (output valid, output printed_value, output halted, input ready);
    modport sink   (input valid, input printed_value, input halted, output ready);
endinterface

// File: design/ism_alu.sv
`timescale 1ns / 1ps

module ism_alu
(
    input  ism_pkg::kind_t kind,
    input  ism_pkg::word_t a,
    input  ism_pkg::word_t b,
    output ism_pkg::word_t r
);

    logic [2*ism_pkg::WordW-1:0] prod;

    // Wrap every result to the word width
    assign prod = a * b;

    always_comb
    begin
        case (kind)
            ism_pkg::OP_ADD: r = a + b;
            ism_pkg::OP_SUB: r = a - b;
            ism_pkg::OP_MUL: r = prod[ism_pkg::WordW-1:0];
            default:         r = '0;
        endcase
    end

endmodule

// File: design/integer_stack_machine.sv
// The instruction executes in the cycle after it is accepted, and its result item is
// registered at the end of that cycle. No new instruction item is taken while one
// executes, because of the read-then-execute pass over the single-read-port stack
// memory and variable memory.
// Reset: asynchronous, active low; clears depth, the halt flag and the output slot,
// then a clearing pass zeroes the variable memory with no item taken.
`timescale 1ns / 1ps

module integer_stack_machine
#(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_COUNT   = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    ism_cmd_if.sink        cmd,
    ism_res_if.source      res
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam logic [VW-1:0] VLAST = VW'(VAR_COUNT - 1);

    // Memories
    ism_pkg::word_t stk_mem [STACK_DEPTH];
    ism_pkg::word_t var_mem [VAR_COUNT];

    // Control state
    logic [DW-1:0]  depth_reg, depth_next;
    ism_pkg::word_t top_reg, top_next;
    logic           stopped_reg, stopped_next;
    logic           exec_reg;
    logic           clear_reg;
    logic [VW-1:0]  clr_cnt_reg;
    logic           out_valid_reg, out_valid_next;

    // Payload registers
    ism_pkg::kind_t kind_reg;
    ism_pkg::word_t cval_reg;
    logic [VW-1:0]  vidx_reg;
    logic           vidx_ok_reg;
    ism_pkg::word_t stk_rd_reg;
    ism_pkg::word_t var_rd_reg;
    ism_pkg::word_t out_value_reg, out_value_next;
    logic           out_halted_reg, out_halted_next;

    logic           accept;
    logic [DW-1:0]  depth_m1;
    logic [DW-1:0]  depth_m2;
    logic [15:0]    vidx_ext;
    logic           vidx_ok;
    logic           empty;
    logic           full;
    logic           two_up;
    ism_pkg::word_t pop_val;
    ism_pkg::word_t sec_val;
    ism_pkg::word_t alu_r;
    ism_pkg::word_t push_val;
    logic           do_push;

    logic           stk_we;
    ism_pkg::word_t stk_wdata;
    logic           var_we;
    logic [VW-1:0]  var_waddr;
    ism_pkg::word_t var_wdata;

    // Take an item only between executions, outside the clearing pass and once the output slot frees
    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !exec_reg && !clear_reg && (!out_valid_reg || res.ready);

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign vidx_ext = 16'(cmd.var_index);
    assign vidx_ok  = vidx_ext < 16'(VAR_COUNT);

    assign empty  = depth_reg == '0;
    assign full   = depth_reg == DW'(STACK_DEPTH);
    assign two_up = depth_reg > DW'(1);

    assign pop_val = empty ? '0 : top_reg;
    assign sec_val = two_up ? stk_rd_reg : '0;

    ism_alu u_alu
    (
        .kind (kind_reg),
        .a    (sec_val),
        .b    (pop_val),
        .r    (alu_r)
    );

    // Execute the held instruction against cached top and the read entries, or clear one variable
    always_comb
    begin
        depth_next      = depth_reg;
        top_next        = top_reg;
        stopped_next    = stopped_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_halted_next = out_halted_reg;
        stk_we          = 1'b0;
        stk_wdata       = top_reg;
        var_we          = 1'b0;
        var_waddr       = vidx_reg;
        var_wdata       = pop_val;
        do_push         = 1'b0;
        push_val        = cval_reg;

        if (clear_reg)
        begin
            var_we    = 1'b1;
            var_waddr = clr_cnt_reg;
            var_wdata = '0;
        end
        else if (exec_reg && !stopped_reg)
        begin
            case (kind_reg)
                ism_pkg::OP_CONST:
                begin
                    do_push  = 1'b1;
                    push_val = cval_reg;
                end
                ism_pkg::OP_LOAD:
                begin
                    do_push  = 1'b1;
                    push_val = vidx_ok_reg ? var_rd_reg : '0;
                end
                ism_pkg::OP_STORE:
                begin
                    var_we = vidx_ok_reg;
                    if (!empty)
                    begin
                        depth_next = depth_m1;
                        top_next   = stk_rd_reg;
                    end
                end
                ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL:
                begin
                    top_next   = alu_r;
                    depth_next = two_up ? depth_m1 : DW'(1);
                end
                ism_pkg::OP_EMIT:
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pop_val;
                    out_halted_next = 1'b0;
                    if (!empty)
                    begin
                        depth_next = depth_m1;
                        top_next   = stk_rd_reg;
                    end
                end
                ism_pkg::OP_HALT:
                begin
                    stopped_next    = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_halted_next = 1'b1;
                end
                default:
                begin
                    depth_next = depth_reg;
                end
            endcase

            // Spill the old top below the new one; drop pushes onto a full stack
            if (do_push && !full)
            begin
                stk_we     = !empty;
                top_next   = push_val;
                depth_next = depth_reg + DW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            stopped_reg   <= 1'b0;
            exec_reg      <= 1'b0;
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            stopped_reg   <= stopped_next;
            exec_reg      <= accept;
            out_valid_reg <= out_valid_next;
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + VW'(1);
                if (clr_cnt_reg == VLAST)
                begin
                    clear_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        out_value_reg  <= out_value_next;
        out_halted_reg <= out_halted_next;
        if (accept)
        begin
            kind_reg    <= cmd.kind;
            cval_reg    <= cmd.constant_value;
            vidx_reg    <= vidx_ext[VW-1:0];
            vidx_ok_reg <= vidx_ok;
        end
    end

    // Stack memory: read the entry under the top on accept, write spills
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stk_rd_reg <= stk_mem[depth_m2[AW-1:0]];
        end
        if (stk_we)
        begin
            stk_mem[depth_m1[AW-1:0]] <= stk_wdata;
        end
    end

    // Variable memory: read the slot on accept, write stores and clearing pass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            var_rd_reg <= var_mem[vidx_ext[VW-1:0]];
        end
        if (var_we)
        begin
            var_mem[var_waddr] <= var_wdata;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.printed_value = out_value_reg;
    assign res.halted        = out_halted_reg;

endmodule

// File: design/ism_checker.sv
`timescale 1ns / 1ps

module ism_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input ism_pkg::word_t res_printed_value,
    input logic           res_halted
);

    // No two items taken in adjacent cycles
    a_accept_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("item accepted while previous item executes");

    // A result only shows up after an item was taken and executed
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result appeared without an accepted item");

    // The halt result carries a zero value
    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_halted) |-> (res_printed_value == '0))
        else $error("halt result with nonzero value");

    // Nothing follows the delivered halt result
    a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res_halted) |=> !res_valid)
        else $error("result after halt");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_printed_value)
                                       && $stable(res_halted)))
        else $error("stalled result changed");

endmodule

bind integer_stack_machine ism_checker u_ism_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_printed_value (res.printed_value),
    .res_halted        (res.halted)
);
